// File: sv/gwa_pkg.sv
// Shared constants and command type for the gated window average block.
package gwa_pkg;

  localparam int SAMPLES  = 8;
  localparam int DIST_W   = 16;
  localparam int PTR_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W    = $clog2(SAMPLES + 1);
  localparam int SUM_W    = DIST_W + CNT_W;
  localparam int DIV_CW   = $clog2(SUM_W);
  localparam int GOOD_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W  = ((DIST_W + GOOD_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_MIN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX = CFG_IDX_W'(1);

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [PTR_W-1:0] rd_addr;
    logic             div_init;
    logic             div_step;
    logic             load_out;
  } gwa_cmd_t;

endpackage

// File: sv/gwa_ctrl.sv
// Controller: sequences ring write, ring walk, serial divide and result hand-off.
module gwa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output gwa_pkg::gwa_cmd_t cmd
);
  import gwa_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WALK   = 3'd1;
  localparam logic [2:0] ST_SETTLE = 3'd2;
  localparam logic [2:0] ST_DINIT  = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FIN    = 3'd5;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [PTR_W-1:0]  walk;
  logic [DIV_CW-1:0] step;
  logic              out_valid;
  logic              accept;
  logic              out_free;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_WALK;
      ST_WALK:   if (walk == PTR_W'(SAMPLES - 1)) state_next = ST_SETTLE;
      ST_SETTLE: state_next = ST_DINIT;
      ST_DINIT:  state_next = ST_DIV;
      ST_DIV:    if (step == DIV_CW'(SUM_W - 1)) state_next = ST_FIN;
      ST_FIN:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.wr       = accept;
    cmd.rd       = (state == ST_WALK);
    cmd.rd_addr  = walk;
    cmd.div_init = (state == ST_DINIT);
    cmd.div_step = (state == ST_DIV);
    cmd.load_out = (state == ST_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      walk      <= '0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WALK) walk <= walk + PTR_W'(1);
      else walk <= '0;
      if (state == ST_DIV) step <= step + DIV_CW'(1);
      else step <= '0;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (m_tready) out_valid <= 1'b0;
    end
  end

endmodule

// File: sv/gwa_dp.sv
// Datapath: gate registers, sample ring, gated accumulator, restoring divider, result register.
module gwa_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  gwa_pkg::gwa_cmd_t             cmd,
  input  logic [gwa_pkg::DIST_W-1:0]    distance_mm,
  input  logic                          cfg_we,
  input  logic [gwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwa_pkg::DIST_W-1:0]    cfg_data,
  output logic [gwa_pkg::DIST_W-1:0]    average_mm,
  output logic                          no_target,
  output logic [gwa_pkg::GOOD_W-1:0]    good_count
);
  import gwa_pkg::*;

  logic [DIST_W-1:0] min_distance_mm;
  logic [DIST_W-1:0] max_distance_mm;
  logic [DIST_W-1:0] ring [SAMPLES];
  logic [SAMPLES-1:0] filled;
  logic [PTR_W-1:0]  wp;
  logic [DIST_W-1:0] rd_data;
  logic              rd_filled;
  logic              acc_en;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic              hit;

  assign hit     = rd_filled && (rd_data > min_distance_mm) && (rd_data < max_distance_mm);
  assign shifted = {rem, quo[SUM_W-1]};
  assign diff    = shifted - {1'b0, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_mm <= DIST_W'(20);
      max_distance_mm <= DIST_W'(4000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN: min_distance_mm <= cfg_data;
        REG_MAX: max_distance_mm <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) ring[wp] <= distance_mm;
    if (cmd.rd) rd_data <= ring[cmd.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      wp        <= '0;
      rd_filled <= 1'b0;
      acc_en    <= 1'b0;
    end else begin
      if (cmd.wr) begin
        filled[wp] <= 1'b1;
        wp <= (wp == PTR_W'(SAMPLES - 1)) ? '0 : wp + PTR_W'(1);
      end
      rd_filled <= filled[cmd.rd_addr];
      acc_en    <= cmd.rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      sum   <= '0;
      count <= '0;
    end else if (acc_en && hit) begin
      sum   <= sum + SUM_W'(rd_data);
      count <= count + CNT_W'(1);
    end
    if (cmd.div_init) begin
      quo <= sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (!diff[CNT_W]) begin
        rem <= diff[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= shifted[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      average_mm <= (count == '0) ? '0 : quo[DIST_W-1:0];
      no_target  <= (count == '0);
      good_count <= GOOD_W'(count);
    end
  end

endmodule

// File: sv/gated_window_average.sv
// Top level of the gated window average block.
// Input stream s_*: one 16-bit distance sample in millimetres per item.
// Output stream m_*: one result per input item: mean of the stored readings
// strictly inside the gate (min_distance_mm, max_distance_mm), their count,
// and a no-target flag when none qualify.
// Config channel cfg_*: index 0 sets min_distance_mm, index 1 max_distance_mm.
// Writes are always taken; write only while no item is in flight.
// Each item is written into an 8-entry ring, the ring is walked one entry per
// cycle through its single read port, then a restoring divider produces one
// quotient bit per cycle over the 20-bit sum.
// After accept the controller walks the ring (WALK), lets the last reading
// accumulate (SETTLE), loads the divider (DINIT), divides (DIV) and loads the result
// (FIN); a new item is taken only back in IDLE, so the ring walk and the serial divide set the item rate.
// The result register holds while m_tready is low; a following item may be
// accepted and processed, but its result waits until the register is taken.
// Reset clears the ring's fill flags (unfilled entries are skipped), the write
// pointer, sets the gate registers to 20 and 4000, and drops m_tvalid.
module gated_window_average (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gwa_pkg::DIST_W-1:0]    s_tdata,   // [15:0] distance_mm
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gwa_pkg::TDATA_W-1:0]   m_tdata,   // [15:0] average_mm, [19:16] good_count
  output logic [0:0]                    m_tuser,   // [0] no_target
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gwa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gwa_pkg::DIST_W-1:0]    cfg_data
);
  import gwa_pkg::*;

  gwa_cmd_t          cmd;
  logic [DIST_W-1:0] average_mm;
  logic              no_target;
  logic [GOOD_W-1:0] good_count;

  assign cfg_ready = 1'b1;
  assign m_tdata   = TDATA_W'({good_count, average_mm});
  assign m_tuser   = no_target;

  gwa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  gwa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .distance_mm (s_tdata),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .average_mm  (average_mm),
    .no_target   (no_target),
    .good_count  (good_count)
  );

endmodule

// File: sv/gwa_chk.sv
// Port-level checker for the gated window average block, bound to the top level.
module gwa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [gwa_pkg::TDATA_W-1:0]   m_tdata,
  input logic [0:0]                    m_tuser
);
  import gwa_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_no_target_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[DIST_W+GOOD_W-1:0] == '0)
    else $error("no-target result carries a mean or count");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind gated_window_average gwa_chk u_gwa_chk (.*);
